[hw/rtl/pea_pkg.sv]
// Package: shared constants, types and status codes of the page extent allocator.
package pea_pkg;
  localparam int MaxExtents = 16;
  localparam int CountBits  = 24;
  localparam int PageBits   = 40;
  localparam int IdxBits    = $clog2(MaxExtents);
  localparam int UsedBits   = $clog2(MaxExtents + 1);

  typedef logic [PageBits-1:0]  page_t;
  typedef logic [CountBits-1:0] len_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [UsedBits-1:0]  used_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // table edit the controller asks of the datapath
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_SHRINK = 3'd1,
    OP_DROP   = 3'd2,
    OP_GROWLO = 3'd3,
    OP_GROWHI = 3'd4,
    OP_MERGE  = 3'd5,
    OP_OPEN   = 3'd6
  } op_t;

  typedef struct packed {
    logic load;   // capture the request
    logic scan;   // evaluate the table
    logic apply;  // perform the edit
  } cmd_t;

  typedef struct packed {
    status_t status;
    op_t     op;
  } stat_t;
endpackage

[hw/rtl/pea_if.sv]
// Interfaces: request and result channels.
interface pea_req_if;
  logic          valid;
  logic          ready;
  logic          command;
  logic [39:0]   page_number;
  logic [23:0]   page_count;
  modport source (output valid, command, page_number, page_count, input ready);
  modport sink   (input valid, command, page_number, page_count, output ready);
endinterface

interface pea_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [39:0] granted_page;
  modport source (output valid, status, granted_page, input ready);
  modport sink   (input valid, status, granted_page, output ready);
endinterface

[hw/rtl/pea_datapath.sv]
// Datapath: extent table, parallel fit/overlap evaluation and table edits.
module pea_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pea_pkg::cmd_t       cmd,
  input  logic                in_command,
  input  logic [39:0]         in_page,
  input  logic [23:0]         in_count,
  output pea_pkg::stat_t      stat,
  output pea_pkg::page_t      granted
);
  localparam int N = pea_pkg::MaxExtents;

  pea_pkg::page_t start_q [N];
  pea_pkg::len_t  len_q   [N];
  logic [N-1:0]   valid;
  pea_pkg::used_t used;

  logic           op_cmd;
  pea_pkg::page_t op_page;
  pea_pkg::len_t  op_count;

  // evaluation results registered for the edit step
  pea_pkg::stat_t ev, ev_next;
  pea_pkg::idx_t  ev_idx, ev_idx_next;
  pea_pkg::page_t ev_grant, ev_grant_next;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd   <= in_command;
      op_page  <= in_page;
      op_count <= in_count[pea_pkg::CountBits-1:0];
    end
  end

  // per-slot compares, all independent
  logic [N-1:0] eq_v, gt_v, ovl_v, lt_v;
  logic [pea_pkg::PageBits:0] run_end;
  assign run_end = {1'b0, op_page} + {{(pea_pkg::PageBits+1-pea_pkg::CountBits){1'b0}}, op_count};

  always_comb begin
    logic [pea_pkg::PageBits:0] e_end;
    for (int i = 0; i < N; i++) begin
      e_end    = {1'b0, start_q[i]} +
                 {{(pea_pkg::PageBits+1-pea_pkg::CountBits){1'b0}}, len_q[i]};
      eq_v[i]  = valid[i] && len_q[i] == op_count;
      gt_v[i]  = valid[i] && len_q[i] >  op_count;
      ovl_v[i] = valid[i] && ({1'b0, op_page} < e_end) && ({1'b0, start_q[i]} < run_end);
      lt_v[i]  = valid[i] && start_q[i] < op_page;
    end
  end

  // pick first fit for an allocation, or the insert position and edit for a free
  always_comb begin
    logic found;
    logic below, above;
    logic [pea_pkg::CountBits+1:0] s3, s2a, s2b;
    pea_pkg::idx_t pos_lo;
    pea_pkg::used_t pos;
    found         = 1'b0;
    ev_next       = '{status: pea_pkg::ST_OK, op: pea_pkg::OP_NONE};
    ev_idx_next   = '0;
    ev_grant_next = '0;
    pos           = '0;
    below = 1'b0; above = 1'b0;
    s3 = '0; s2a = '0; s2b = '0;
    pos_lo = '0;
    for (int i = 0; i < N; i++) begin
      if (lt_v[i]) pos = pea_pkg::used_t'(i + 1);
    end
    if (op_count == '0) begin
      ev_next.status = pea_pkg::ST_ZERO;
    end else if (op_cmd == pea_pkg::CMD_ALLOC) begin
      ev_next.status = pea_pkg::ST_NOFIT;
      for (int i = 0; i < N; i++) begin
        if (!found && (eq_v[i] || gt_v[i])) begin
          found          = 1'b1;
          ev_idx_next    = pea_pkg::idx_t'(i);
          ev_grant_next  = start_q[i];
          ev_next.status = pea_pkg::ST_OK;
          ev_next.op     = eq_v[i] ? pea_pkg::OP_DROP : pea_pkg::OP_SHRINK;
        end
      end
    end else if (run_end[pea_pkg::PageBits] && run_end[pea_pkg::PageBits-1:0] != '0) begin
      ev_next.status = pea_pkg::ST_NOFIT;
    end else if (|ovl_v) begin
      ev_next.status = pea_pkg::ST_OVERLAP;
    end else begin
      pos_lo = pea_pkg::idx_t'(pos - 1'b1);
      if (pos != '0)
        below = ({1'b0, start_q[pos_lo]} +
                 {{(pea_pkg::PageBits+1-pea_pkg::CountBits){1'b0}}, len_q[pos_lo]})
                == {1'b0, op_page};
      if (pos < used)
        above = {1'b0, start_q[pea_pkg::idx_t'(pos)]} == run_end;
      s2a = {2'b0, len_q[pos_lo]} + {2'b0, op_count};
      s2b = {2'b0, len_q[pea_pkg::idx_t'(pos)]} + {2'b0, op_count};
      s3  = s2a + {2'b0, len_q[pea_pkg::idx_t'(pos)]};
      if (below && above && s3[pea_pkg::CountBits+1:pea_pkg::CountBits] == 2'b0) begin
        ev_next.op = pea_pkg::OP_MERGE;
        ev_idx_next = pos_lo;
      end else if (below && s2a[pea_pkg::CountBits] == 1'b0) begin
        ev_next.op = pea_pkg::OP_GROWLO;
        ev_idx_next = pos_lo;
      end else if (above && s2b[pea_pkg::CountBits] == 1'b0) begin
        ev_next.op = pea_pkg::OP_GROWHI;
        ev_idx_next = pea_pkg::idx_t'(pos);
      end else if (used == pea_pkg::used_t'(N)) begin
        ev_next.status = pea_pkg::ST_FULL;
      end else begin
        ev_next.op = pea_pkg::OP_OPEN;
        ev_idx_next = pea_pkg::idx_t'(pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '{status: pea_pkg::ST_OK, op: pea_pkg::OP_NONE};
    end else if (cmd.scan) begin
      ev <= ev_next;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      ev_idx   <= ev_idx_next;
      ev_grant <= ev_grant_next;
    end
  end

  // apply the edit; shifts move all slots at once
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      unique case (ev.op)
        pea_pkg::OP_SHRINK: begin
          start_q[ev_idx] <= start_q[ev_idx] + pea_pkg::page_t'(op_count);
          len_q[ev_idx]   <= len_q[ev_idx] - op_count;
        end
        pea_pkg::OP_DROP: begin
          for (int i = 0; i < N - 1; i++) begin
            if (i >= int'(ev_idx)) begin
              start_q[i] <= start_q[i+1];
              len_q[i]   <= len_q[i+1];
            end
          end
        end
        pea_pkg::OP_GROWLO: len_q[ev_idx] <= len_q[ev_idx] + op_count;
        pea_pkg::OP_GROWHI: begin
          start_q[ev_idx] <= op_page;
          len_q[ev_idx]   <= len_q[ev_idx] + op_count;
        end
        pea_pkg::OP_MERGE: begin
          len_q[ev_idx] <= len_q[ev_idx] + op_count + len_q[pea_pkg::idx_t'(ev_idx + 1'b1)];
          for (int i = 1; i < N - 1; i++) begin
            if (i > int'(ev_idx)) begin
              start_q[i] <= start_q[i+1];
              len_q[i]   <= len_q[i+1];
            end
          end
        end
        pea_pkg::OP_OPEN: begin
          for (int i = 1; i < N; i++) begin
            if (i > int'(ev_idx)) begin
              start_q[i] <= start_q[i-1];
              len_q[i]   <= len_q[i-1];
            end
          end
          start_q[ev_idx] <= op_page;
          len_q[ev_idx]   <= op_count;
        end
        default: ;
      endcase
    end
  end

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      valid <= '0;
    end else if (cmd.apply) begin
      if (ev.op == pea_pkg::OP_DROP || ev.op == pea_pkg::OP_MERGE) begin
        used  <= used - 1'b1;
        valid <= valid >> 1;
      end else if (ev.op == pea_pkg::OP_OPEN) begin
        used  <= used + 1'b1;
        valid <= {valid[N-2:0], 1'b1};
      end
    end
  end

  assign stat    = ev;
  assign granted = ev_grant;

  a_used_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used)) else $error("occupancy mismatch");
  a_open_room: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && ev.op == pea_pkg::OP_OPEN |-> used < pea_pkg::used_t'(N))
    else $error("open on full table");
  a_err_no_edit: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && ev_next.status != pea_pkg::ST_OK |-> ev_next.op == pea_pkg::OP_NONE)
    else $error("edit on error");
endmodule

[hw/rtl/pea_ctrl.sv]
// Controller: sequences load, scan, apply and result hand-off.
module pea_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output pea_pkg::cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN;
      S_SCAN:  state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign cmd = '{load:  in_valid && in_ready,
                 scan:  state == S_SCAN,
                 apply: state == S_APPLY};

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scan ##1 cmd.apply) else $error("sequence broken");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept while holding result");
endmodule

[hw/rtl/page_extent_allocator.sv]
// Top level: first-fit free page extent allocator.
// The result passes through the scan and apply states before it is offered.
// A new item is accepted only after the previous result has been taken, as
// the controller runs a single table scan and edit sequence per item.
// Reset (synchronous rst) empties the extent table; contents need no clearing.
module page_extent_allocator (
  input logic clk,
  input logic rst,
  pea_req_if.sink   req,
  pea_rsp_if.source rsp
);
  pea_pkg::cmd_t  cmd;
  pea_pkg::stat_t stat;
  pea_pkg::page_t granted;

  pea_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid), .in_ready (req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd
  );

  pea_datapath u_dp (
    .clk, .rst, .cmd,
    .in_command(req.command), .in_page(req.page_number), .in_count(req.page_count),
    .stat, .granted
  );

  assign rsp.status       = stat.status;
  assign rsp.granted_page = (stat.status == pea_pkg::ST_OK) ? granted : '0;
endmodule

[tb/tb_top.sv]
// Testbench top: drives the page extent allocator and checks each result against a table model.
`timescale 1ns / 1ps

class extent_scoreboard;
  pea_pkg::page_t   ext_start[$];
  pea_pkg::len_t    ext_len[$];
  pea_pkg::status_t exp_status[$];
  pea_pkg::page_t   exp_page[$];
  int               errors;

  function new();
    errors = 0;
  endfunction

  // apply one request to the free list and queue the answer
  function void note_request(logic cmd, pea_pkg::page_t page, pea_pkg::len_t count);
    pea_pkg::status_t st;
    pea_pkg::page_t   granted;
    logic [40:0]      run_end;
    logic [40:0]      e_end;
    int               pos;
    bit               below, above, done;
    st = pea_pkg::ST_OK;
    granted = '0;
    done = 0;
    if (count == 0) begin
      st = pea_pkg::ST_ZERO;
    end else if (cmd == pea_pkg::CMD_ALLOC) begin
      st = pea_pkg::ST_NOFIT;
      foreach (ext_len[i]) begin
        if (!done && ext_len[i] >= count) begin
          granted = ext_start[i];
          st = pea_pkg::ST_OK;
          done = 1;
          if (ext_len[i] == count) begin
            ext_start.delete(i);
            ext_len.delete(i);
          end else begin
            ext_start[i] = ext_start[i] + count;
            ext_len[i] = ext_len[i] - count;
          end
        end
      end
    end else begin
      run_end = {1'b0, page} + count;
      if (run_end[40] && run_end[39:0] != 0) st = pea_pkg::ST_NOFIT;
      else begin
        foreach (ext_start[i]) begin
          e_end = {1'b0, ext_start[i]} + ext_len[i];
          if ({1'b0, page} < e_end && {1'b0, ext_start[i]} < run_end) st = pea_pkg::ST_OVERLAP;
        end
      end
      if (st == pea_pkg::ST_OK) begin
        pos = 0;
        while (pos < ext_start.size() && ext_start[pos] < page) pos++;
        below = pos > 0 && ({1'b0, ext_start[pos-1]} + ext_len[pos-1]) == {1'b0, page};
        above = pos < ext_start.size() && {1'b0, ext_start[pos]} == run_end;
        if (below && above && ({1'b0, ext_len[pos-1]} + count + ext_len[pos]) < 26'(1 << 24))
        begin
          ext_len[pos-1] = ext_len[pos-1] + count + ext_len[pos];
          ext_start.delete(pos);
          ext_len.delete(pos);
        end else if (below && ({1'b0, ext_len[pos-1]} + count) <= 25'hFFFFFF) begin
          ext_len[pos-1] = ext_len[pos-1] + count;
        end else if (above && ({1'b0, ext_len[pos]} + count) <= 25'hFFFFFF) begin
          ext_start[pos] = page;
          ext_len[pos] = ext_len[pos] + count;
        end else if (ext_start.size() >= pea_pkg::MaxExtents) begin
          st = pea_pkg::ST_FULL;
        end else begin
          ext_start.insert(pos, page);
          ext_len.insert(pos, count);
        end
      end
    end
    exp_status.push_back(st);
    exp_page.push_back(st == pea_pkg::ST_OK ? granted : '0);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // compare one result with the oldest expectation
  task check_result(logic [2:0] status, pea_pkg::page_t page);
    if (exp_status.size() == 0) begin
      report($sformatf("unexpected result status %0d", status));
      return;
    end
    if (status != exp_status[0])
      report($sformatf("status %0d, want %0d", status, exp_status[0]));
    if (page != exp_page[0])
      report($sformatf("granted_page %h, want %h", page, exp_page[0]));
    void'(exp_status.pop_front());
    void'(exp_page.pop_front());
  endtask
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  bit   calm = 0;
  pea_req_if req();
  pea_rsp_if rsp();
  extent_scoreboard board = new();

  page_extent_allocator dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always #4 clk = ~clk;

  initial begin
    req.valid = 0;
    req.command = 0;
    req.page_number = '0;
    req.page_count = '0;
    rsp.ready = 0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      board.note_request(req.command, req.page_number, req.page_count);
    if (!rst && rsp.valid && rsp.ready)
      board.check_result(rsp.status, rsp.granted_page);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(negedge clk);
    forever begin
      rsp.ready <= 1;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 0;
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk);
      end
    end
  end

  // present one item and hold it until accepted
  task automatic send_item(logic cmd, pea_pkg::page_t page, pea_pkg::len_t count);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 0;
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk);
    end
    req.valid <= 1;
    req.command <= cmd;
    req.page_number <= page;
    req.page_count <= count;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (board.exp_status.size() != 0) @(negedge clk);
  endtask

  // pick an allocation, or a free run near existing extents, or a random one
  task automatic random_item();
    pea_pkg::page_t p;
    pea_pkg::len_t  c;
    int             k, sel;
    sel = $urandom_range(0, 99);
    c = (sel < 5) ? pea_pkg::len_t'({$urandom, $urandom})
                  : pea_pkg::len_t'($urandom_range(0, 40));
    if ($urandom_range(0, 1) == 0) begin
      send_item(pea_pkg::CMD_ALLOC, pea_pkg::page_t'({$urandom, $urandom}), c);
    end else begin
      if (sel < 8) p = pea_pkg::page_t'({$urandom, $urandom});
      else if (board.ext_start.size() > 0 && sel < 60) begin
        k = $urandom_range(0, board.ext_start.size() - 1);
        if ($urandom_range(0, 1)) p = board.ext_start[k] + board.ext_len[k];
        else p = board.ext_start[k] - c;
        p = p + $urandom_range(0, 3) - 1;
      end else p = pea_pkg::page_t'($urandom_range(0, 3000));
      send_item(pea_pkg::CMD_FREE, p, c);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: zero counts, empty table, edges of the page space, merges, overlap and first fit
    send_item(pea_pkg::CMD_ALLOC, '0, '0);
    send_item(pea_pkg::CMD_FREE, '1, '0);
    send_item(pea_pkg::CMD_ALLOC, '0, 24'd1);
    send_item(pea_pkg::CMD_FREE, '1, 24'd2);
    send_item(pea_pkg::CMD_FREE, '1, 24'd1);
    send_item(pea_pkg::CMD_FREE, 40'hFF_FFFF_0000, 24'hFF_FFFF);
    send_item(pea_pkg::CMD_FREE, '0, 24'hFF_FFFF);
    send_item(pea_pkg::CMD_FREE, 40'h100_0000, 24'd1);
    send_item(pea_pkg::CMD_FREE, 40'hFF_FFFF, 24'd1);
    send_item(pea_pkg::CMD_FREE, 40'd10, 24'd5);
    send_item(pea_pkg::CMD_ALLOC, '0, 24'hFF_FFFF);
    send_item(pea_pkg::CMD_ALLOC, '0, 24'hFF_FFFE);
    send_item(pea_pkg::CMD_FREE, 40'd100, 24'd10);
    send_item(pea_pkg::CMD_FREE, 40'd120, 24'd10);
    send_item(pea_pkg::CMD_FREE, 40'd110, 24'd10);
    send_item(pea_pkg::CMD_FREE, 40'd105, 24'd10);
    send_item(pea_pkg::CMD_ALLOC, '0, 24'd30);
    send_item(pea_pkg::CMD_ALLOC, '0, 24'd4);
    send_item(pea_pkg::CMD_ALLOC, '0, 24'd1000);
    drain();
    // fill the table to force the full status
    for (int i = 0; i < pea_pkg::MaxExtents + 2; i++)
      send_item(pea_pkg::CMD_FREE, 40'd5000 + 40'(i) * 3, 24'd1);
    drain();
    // random part, quiet at the end
    for (int i = 0; i < 1000; i++) begin
      if (i == 850) calm = 1;
      random_item();
    end
    drain();
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.exp_status.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end
endmodule

[page_extent_allocator.f]
hw/rtl/pea_pkg.sv
hw/rtl/pea_if.sv
hw/rtl/pea_datapath.sv
hw/rtl/pea_ctrl.sv
hw/rtl/page_extent_allocator.sv
tb/tb_top.sv
